// ----- rtl/fpa_pkg.sv -----
// Shared types for the Q24.8 fixed-point ALU: operation codes and the
// per-item flag bundle that rides the control pipeline.
// No dependencies.
`timescale 1ns / 1ps

package fpa_pkg;

  typedef enum logic [3:0] {
    MODE_ADD = 4'd0,
    MODE_SUB = 4'd1,
    MODE_MUL = 4'd2,
    MODE_DIV = 4'd3,
    MODE_MIN = 4'd4,
    MODE_MAX = 4'd5,
    MODE_INC = 4'd6,
    MODE_DEC = 4'd7,
    MODE_I2F = 4'd8,
    MODE_F2I = 4'd9
  } fpa_mode_t;

  typedef struct packed {
    logic gt;
    logic lt;
    logic eq;
    logic ovf;
    logic dz;
  } fpa_flags_t;

endpackage

// ----- rtl/fixed_point_q24_8_alu_top.sv -----
// Top level of the Q24.8 fixed-point ALU: operand stage, control pipeline,
// result select and output skid buffer. Uses fpa_pkg, fpa_mul, fpa_div.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  in_mode, in_operand_a, in_operand_b
//   out_     output     out_valid / out_stall out_result, out_a_greater, out_a_less,
//                                            out_a_equal, out_overflow, out_divide_by_zero
//
// One beat per cycle while the skid slot is empty; out_valid rises once the beat
// has passed the control pipeline, whose depth is set by the divider's
// one-quotient-bit-per-stage chain, and then the output slot.
// Reset clears every valid bit and both output slots; payload is not reset.
// A two-entry output buffer parts the sides: in_stall rises only once the
// skid slot holds a beat, and then the whole pipeline holds.
`timescale 1ns / 1ps

module fixed_point_q24_8_alu_top #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [3:0]                  in_mode,
  input  logic signed [WORD_BITS-1:0] in_operand_a,
  input  logic signed [WORD_BITS-1:0] in_operand_b,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [WORD_BITS-1:0] out_result,
  output logic                        out_a_greater,
  output logic                        out_a_less,
  output logic                        out_a_equal,
  output logic                        out_overflow,
  output logic                        out_divide_by_zero
);

  import fpa_pkg::*;

  localparam int DIV_LAT = WORD_BITS + FRAC_BITS + 2;
  localparam int MUL_LAT = 4;
  localparam int MUL_DLY = DIV_LAT - MUL_LAT;
  localparam logic [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  logic en;

  // ---------------------------------------------------------------- operand stage
  fpa_mode_t            mode_in;
  logic [WORD_BITS-1:0] a_u, b_u, sum, dif, sres_nxt, ma_nxt, mb_nxt;
  fpa_flags_t           flg_nxt;
  logic                 ovf_add, ovf_sub;

  always_comb begin
    mode_in = fpa_mode_t'(in_mode);
    a_u     = in_operand_a;
    b_u     = in_operand_b;
    sum     = a_u + b_u;
    dif     = a_u - b_u;
    ovf_add = (a_u[WORD_BITS-1] == b_u[WORD_BITS-1]) &&
              (sum[WORD_BITS-1] != a_u[WORD_BITS-1]);
    ovf_sub = (a_u[WORD_BITS-1] != b_u[WORD_BITS-1]) &&
              (dif[WORD_BITS-1] != a_u[WORD_BITS-1]);
    ma_nxt  = a_u[WORD_BITS-1] ? -a_u : a_u;
    mb_nxt  = b_u[WORD_BITS-1] ? -b_u : b_u;

    flg_nxt.gt  = in_operand_a > in_operand_b;
    flg_nxt.lt  = in_operand_a < in_operand_b;
    flg_nxt.eq  = a_u == b_u;
    flg_nxt.ovf = 1'b0;
    flg_nxt.dz  = (mode_in == MODE_DIV) && (b_u == '0);

    case (mode_in)
      MODE_ADD: begin
        flg_nxt.ovf = ovf_add;
        sres_nxt    = ovf_add ? (a_u[WORD_BITS-1] ? WMIN : WMAX) : sum;
      end
      MODE_SUB: begin
        flg_nxt.ovf = ovf_sub;
        sres_nxt    = ovf_sub ? (a_u[WORD_BITS-1] ? WMIN : WMAX) : dif;
      end
      MODE_MIN: sres_nxt = flg_nxt.gt ? b_u : a_u;
      MODE_MAX: sres_nxt = flg_nxt.gt ? a_u : b_u;
      MODE_INC: sres_nxt = a_u + {{(WORD_BITS-1){1'b0}}, 1'b1};
      MODE_DEC: sres_nxt = a_u - {{(WORD_BITS-1){1'b0}}, 1'b1};
      MODE_I2F: sres_nxt = a_u << FRAC_BITS;
      MODE_F2I: sres_nxt = in_operand_a >>> FRAC_BITS;
      default:  sres_nxt = '0;
    endcase
  end

  logic [WORD_BITS-1:0] ma_r, mb_r;
  logic                 neg_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r  <= ma_nxt;
      mb_r  <= mb_nxt;
      neg_r <= a_u[WORD_BITS-1] ^ b_u[WORD_BITS-1];
    end
  end

  // ---------------------------------------------------------------- control pipeline
  logic                 cv_r   [DIV_LAT+1];
  fpa_mode_t            cmode_r[DIV_LAT+1];
  logic [WORD_BITS-1:0] cres_r [DIV_LAT+1];
  fpa_flags_t           cflg_r [DIV_LAT+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= DIV_LAT; i++) begin
        cv_r[i] <= 1'b0;
      end
    end else if (en) begin
      cv_r[0] <= in_valid;
      for (int i = 1; i <= DIV_LAT; i++) begin
        cv_r[i] <= cv_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmode_r[0] <= mode_in;
      cres_r[0]  <= sres_nxt;
      cflg_r[0]  <= flg_nxt;
      for (int i = 1; i <= DIV_LAT; i++) begin
        cmode_r[i] <= cmode_r[i-1];
        cres_r[i]  <= cres_r[i-1];
        cflg_r[i]  <= cflg_r[i-1];
      end
    end
  end

  // ---------------------------------------------------------------- arithmetic units
  logic [WORD_BITS-1:0] mul_res, div_res;
  logic                 mul_ovf, div_ovf;

  fpa_mul #(
    .WORD_BITS(WORD_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk(clk),
    .en (en),
    .ma (ma_r),
    .mb (mb_r),
    .neg(neg_r),
    .res(mul_res),
    .ovf(mul_ovf)
  );

  fpa_div #(
    .WORD_BITS(WORD_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk(clk),
    .en (en),
    .ma (ma_r),
    .mb (mb_r),
    .neg(neg_r),
    .res(div_res),
    .ovf(div_ovf)
  );

  // align the short multiplier path with the divider
  logic [WORD_BITS-1:0] md_res_r [MUL_DLY];
  logic                 md_ovf_r [MUL_DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      md_res_r[0] <= mul_res;
      md_ovf_r[0] <= mul_ovf;
      for (int i = 1; i < MUL_DLY; i++) begin
        md_res_r[i] <= md_res_r[i-1];
        md_ovf_r[i] <= md_ovf_r[i-1];
      end
    end
  end

  // ---------------------------------------------------------------- result select
  logic [WORD_BITS-1:0] fin_res;
  fpa_flags_t           fin_flg;

  always_comb begin
    fin_flg = cflg_r[DIV_LAT];
    fin_res = cres_r[DIV_LAT];
    case (cmode_r[DIV_LAT])
      MODE_MUL: begin
        fin_res     = md_res_r[MUL_DLY-1];
        fin_flg.ovf = md_ovf_r[MUL_DLY-1];
      end
      MODE_DIV: begin
        fin_res     = fin_flg.dz ? '0 : div_res;
        fin_flg.ovf = !fin_flg.dz && div_ovf;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- output skid buffer
  logic                 out_v_r, skid_v_r;
  logic [WORD_BITS-1:0] out_res_r, skid_res_r;
  fpa_flags_t           out_flg_r, skid_flg_r;
  logic                 take, incoming;

  assign en       = !skid_v_r;
  assign take     = out_v_r && !out_stall;
  assign incoming = en && cv_r[DIV_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (take) begin
        skid_v_r <= 1'b0;
      end
    end else if (incoming) begin
      if (out_v_r && !take) begin
        skid_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end else if (take) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (take) begin
        out_res_r <= skid_res_r;
        out_flg_r <= skid_flg_r;
      end
    end else if (incoming) begin
      if (out_v_r && !take) begin
        skid_res_r <= fin_res;
        skid_flg_r <= fin_flg;
      end else begin
        out_res_r <= fin_res;
        out_flg_r <= fin_flg;
      end
    end
  end

  assign in_stall           = skid_v_r;
  assign out_valid          = out_v_r;
  assign out_result         = out_res_r;
  assign out_a_greater      = out_flg_r.gt;
  assign out_a_less         = out_flg_r.lt;
  assign out_a_equal        = out_flg_r.eq;
  assign out_overflow       = out_flg_r.ovf;
  assign out_divide_by_zero = out_flg_r.dz;

  // ---------------------------------------------------------------- assertions
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid slot full while output slot empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && out_stall) |=> skid_v_r)
    else $error("skid beat dropped while output stalled");

  a_cmp_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> $onehot({out_flg_r.gt, out_flg_r.lt, out_flg_r.eq}))
    else $error("comparison flags not one-hot");

  a_dz_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_flg_r.dz) |-> (out_res_r == '0 && !out_flg_r.ovf))
    else $error("divide by zero beat carries result or overflow");

endmodule

// ----- rtl/fpa_sat.sv -----
// Registered saturation stage: unsigned magnitude plus sign to a signed word.
// Used by the multiplier and divider; no package dependencies.
`timescale 1ns / 1ps

module fpa_sat #(
  parameter int WORD_BITS = 32,
  parameter int MAG_BITS  = 40
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [MAG_BITS-1:0]  mag,
  input  logic                 neg,
  output logic [WORD_BITS-1:0] res,
  output logic                 ovf
);

  localparam logic [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  logic [WORD_BITS-1:0] res_r, res_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [WORD_BITS-1:0] limit;
  logic [WORD_BITS-1:0] low;

  always_comb begin
    low     = mag[WORD_BITS-1:0];
    limit   = neg ? WMIN : WMAX;
    ovf_nxt = (|mag[MAG_BITS-1:WORD_BITS]) || (low > limit);
    if (ovf_nxt) begin
      res_nxt = limit;
    end else if (neg) begin
      res_nxt = -low;
    end else begin
      res_nxt = low;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign res = res_r;
  assign ovf = ovf_r;

endmodule

// ----- rtl/fpa_mul.sv -----
// Pipelined magnitude multiplier with round half away from zero and saturation.
// Four half-width partial products, then merge, round, saturate (fpa_sat).
`timescale 1ns / 1ps

module fpa_mul #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [WORD_BITS-1:0] ma,
  input  logic [WORD_BITS-1:0] mb,
  input  logic                 neg,
  output logic [WORD_BITS-1:0] res,
  output logic                 ovf
);

  localparam int LO = WORD_BITS / 2;
  localparam int HI = WORD_BITS - LO;
  localparam int PW = 2 * WORD_BITS;
  localparam int QW = PW - FRAC_BITS;
  localparam logic [PW-1:0] RND = {{(PW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

  // partial products
  logic [2*LO-1:0]      ll_r;
  logic [2*HI-1:0]      hh_r;
  logic [WORD_BITS-1:0] lh_r, hl_r;
  logic                 neg1_r;
  // merged terms
  logic [PW-1:0]        cat_r;
  logic [WORD_BITS:0]   mid_r;
  logic                 neg2_r;
  // rounded, scaled magnitude
  logic [QW-1:0]        q_r, q_nxt;
  logic                 neg3_r;
  logic [PW-1:0]        mid_ext, p_sum;

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r   <= (2*LO)'(ma[LO-1:0]) * (2*LO)'(mb[LO-1:0]);
      hh_r   <= (2*HI)'(ma[WORD_BITS-1:LO]) * (2*HI)'(mb[WORD_BITS-1:LO]);
      lh_r   <= WORD_BITS'(ma[WORD_BITS-1:LO]) * WORD_BITS'(mb[LO-1:0]);
      hl_r   <= WORD_BITS'(ma[LO-1:0]) * WORD_BITS'(mb[WORD_BITS-1:LO]);
      neg1_r <= neg;
      cat_r  <= {hh_r, ll_r};
      mid_r  <= {1'b0, lh_r} + {1'b0, hl_r};
      neg2_r <= neg1_r;
      q_r    <= q_nxt;
      neg3_r <= neg2_r;
    end
  end

  always_comb begin
    mid_ext = {{(WORD_BITS-1){1'b0}}, mid_r} << LO;
    p_sum   = cat_r + mid_ext + RND;
    q_nxt   = p_sum[PW-1:FRAC_BITS];
  end

  fpa_sat #(
    .WORD_BITS(WORD_BITS),
    .MAG_BITS (QW)
  ) u_sat (
    .clk(clk),
    .en (en),
    .mag(q_r),
    .neg(neg3_r),
    .res(res),
    .ovf(ovf)
  );

endmodule

// ----- rtl/fpa_div.sv -----
// Pipelined restoring divider: one quotient bit per stage over
// WORD_BITS+FRAC_BITS stages, then round half away from zero and fpa_sat.
`timescale 1ns / 1ps

module fpa_div #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [WORD_BITS-1:0] ma,
  input  logic [WORD_BITS-1:0] mb,
  input  logic                 neg,
  output logic [WORD_BITS-1:0] res,
  output logic                 ovf
);

  localparam int QW = WORD_BITS + FRAC_BITS;

  logic [WORD_BITS-1:0] rem_r [QW];
  logic [WORD_BITS-1:0] den_r [QW];
  logic [QW-1:0]        num_r [QW];
  logic [QW-1:0]        quo_r [QW];
  logic                 neg_r [QW];

  genvar k;
  generate
    for (k = 0; k < QW; k++) begin : g_step
      logic [WORD_BITS-1:0] rem_in, den_in, rem_nxt;
      logic [QW-1:0]        num_in, quo_in;
      logic                 neg_in, ge;
      logic [WORD_BITS:0]   trial, diff;

      if (k == 0) begin : g_first
        assign rem_in = '0;
        assign den_in = mb;
        assign num_in = {ma, {FRAC_BITS{1'b0}}};
        assign quo_in = '0;
        assign neg_in = neg;
      end else begin : g_next
        assign rem_in = rem_r[k-1];
        assign den_in = den_r[k-1];
        assign num_in = num_r[k-1];
        assign quo_in = quo_r[k-1];
        assign neg_in = neg_r[k-1];
      end

      // bring down one numerator bit, subtract when it fits
      always_comb begin
        trial   = {rem_in, num_in[QW-1]};
        diff    = trial - {1'b0, den_in};
        ge      = trial >= {1'b0, den_in};
        rem_nxt = ge ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= rem_nxt;
          den_r[k] <= den_in;
          num_r[k] <= {num_in[QW-2:0], 1'b0};
          quo_r[k] <= {quo_in[QW-2:0], ge};
          neg_r[k] <= neg_in;
        end
      end
    end
  endgenerate

  logic [QW:0] qr_r, qr_nxt;
  logic        negr_r;
  logic        round_up;

  // round up when twice the remainder reaches the divisor
  always_comb begin
    round_up = {rem_r[QW-1], 1'b0} >= {1'b0, den_r[QW-1]};
    qr_nxt   = {1'b0, quo_r[QW-1]} + {{QW{1'b0}}, round_up};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qr_r   <= qr_nxt;
      negr_r <= neg_r[QW-1];
    end
  end

  fpa_sat #(
    .WORD_BITS(WORD_BITS),
    .MAG_BITS (QW + 1)
  ) u_sat (
    .clk(clk),
    .en (en),
    .mag(qr_r),
    .neg(negr_r),
    .res(res),
    .ovf(ovf)
  );

endmodule

// ----- bench/fpa_result_checker.sv -----
// Checker for the Q24.8 fixed-point ALU: watches both channels, predicts each
// result beat from the accepted operands and compares it field by field.
// Depends on fpa_pkg for the operation codes.
`timescale 1ns / 1ps

module fpa_result_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [3:0]         in_mode,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_result,
  input  logic               out_a_greater,
  input  logic               out_a_less,
  input  logic               out_a_equal,
  input  logic               out_overflow,
  input  logic               out_divide_by_zero,
  output int                 fail_count,
  output int                 outstanding,
  output int                 checked_count
);

  import fpa_pkg::*;

  localparam int          FRAC     = 8;
  localparam logic [31:0] WORD_MAX = 32'h7fff_ffff;
  localparam logic [31:0] WORD_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] result;
    logic        gt;
    logic        lt;
    logic        eq;
    logic        ovf;
    logic        dz;
  } alu_outcome_t;

  alu_outcome_t predicted_results[$];

  initial begin
    fail_count    = 0;
    outstanding   = 0;
    checked_count = 0;
  end

  // Turn an unsigned magnitude and a sign into a saturated word, overflow on top.
  function automatic logic [32:0] clamp_word(logic [63:0] mag, logic neg);
    if (mag > (neg ? 64'h8000_0000 : 64'h7fff_ffff))
      return {1'b1, neg ? WORD_MIN : WORD_MAX};
    return {1'b0, neg ? 32'(-mag) : mag[31:0]};
  endfunction

  function automatic alu_outcome_t alu_compute(logic [3:0] mode, logic signed [31:0] a,
                                               logic signed [31:0] b);
    alu_outcome_t      o;
    logic signed [63:0] ax, bx;
    logic [63:0]       ma, mb, prod, num, quo, rem;
    logic [31:0]       sum;
    logic              neg, is_add;
    o      = '0;
    o.gt   = a > b;
    o.lt   = a < b;
    o.eq   = a == b;
    ax     = a;
    bx     = b;
    ma     = (ax < 0) ? -ax : ax;
    mb     = (bx < 0) ? -bx : bx;
    neg    = a[31] ^ b[31];
    is_add = (mode == MODE_ADD);
    case (mode)
      MODE_ADD, MODE_SUB: begin
        sum = is_add ? a + b : a - b;
        if ((is_add ? (a[31] == b[31]) : (a[31] != b[31])) && sum[31] != a[31]) begin
          o.ovf    = 1'b1;
          o.result = a[31] ? WORD_MIN : WORD_MAX;
        end else begin
          o.result = sum;
        end
      end
      MODE_MUL: begin
        // round half away from zero on the magnitude, then drop the fraction
        prod = ma * mb + (64'd1 << (FRAC - 1));
        quo  = prod >> FRAC;
        {o.ovf, o.result} = clamp_word(quo, neg);
      end
      MODE_DIV: begin
        if (b == 0) begin
          o.dz = 1'b1;
        end else begin
          num = ma << FRAC;
          quo = num / mb;
          rem = num % mb;
          if (rem >= mb - rem) quo = quo + 1;
          {o.ovf, o.result} = clamp_word(quo, neg);
        end
      end
      MODE_MIN: o.result = o.gt ? b : a;
      MODE_MAX: o.result = o.gt ? a : b;
      MODE_INC: o.result = a + 32'sd1;
      MODE_DEC: o.result = a - 32'sd1;
      MODE_I2F: o.result = a << FRAC;
      MODE_F2I: o.result = a >>> FRAC;
      default:  o.result = '0;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH t=%0t beat %0d %s: got %h, want %h", $time, checked_count, what,
             got, want);
    fail_count++;
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(name, got, want);
  endtask

  always @(posedge clk) begin
    alu_outcome_t want;
    if (rst_n) begin
      // pop before push so an early beat never meets its own prediction
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("unexpected beat", out_result, '0);
        end else begin
          want = predicted_results.pop_front();
          compare_field("result", out_result, want.result);
          compare_field("a_greater", 32'(out_a_greater), 32'(want.gt));
          compare_field("a_less", 32'(out_a_less), 32'(want.lt));
          compare_field("a_equal", 32'(out_a_equal), 32'(want.eq));
          compare_field("overflow", 32'(out_overflow), 32'(want.ovf));
          compare_field("divide_by_zero", 32'(out_divide_by_zero), 32'(want.dz));
        end
        checked_count++;
      end
      if (in_valid && !in_stall)
        predicted_results.push_back(alu_compute(in_mode, in_operand_a, in_operand_b));
      outstanding <= predicted_results.size();
    end
  end

endmodule

// ----- bench/testbench.sv -----
// Top of the fixed-point ALU bench: clock, reset, operand stimulus in bursts
// and a receiver that stalls on its own pattern. Uses fpa_pkg, the ALU top
// and fpa_result_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module testbench;
  import fpa_pkg::*;

  localparam int          RANDOM_ITEMS = 750;
  localparam int          DRAIN_CYCLES = 100;
  localparam int          TIMEOUT_NS   = 2_000_000;
  localparam logic [3:0]  MODE_SPARE_LO = 4'd10;
  localparam logic [3:0]  MODE_SPARE_HI = 4'd15;
  localparam logic [31:0] WORD_MAX = 32'h7fff_ffff;
  localparam logic [31:0] WORD_MIN = 32'h8000_0000;
  localparam logic [31:0] ONE_FIX  = 32'h0000_0100;
  localparam logic [31:0] NEG_ONE  = 32'hffff_ffff;

  typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_PERIODIC} stall_style_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [3:0]         in_mode;
  logic signed [31:0] in_operand_a;
  logic signed [31:0] in_operand_b;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_result;
  logic               out_a_greater;
  logic               out_a_less;
  logic               out_a_equal;
  logic               out_overflow;
  logic               out_divide_by_zero;
  int                 fail_count;
  int                 outstanding;
  int                 checked_count;
  int                 directed_count;
  int                 random_count;

  fixed_point_q24_8_alu_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_operand_a      (in_operand_a),
    .in_operand_b      (in_operand_b),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result        (out_result),
    .out_a_greater     (out_a_greater),
    .out_a_less        (out_a_less),
    .out_a_equal       (out_a_equal),
    .out_overflow      (out_overflow),
    .out_divide_by_zero(out_divide_by_zero)
  );

  fpa_result_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_operand_a      (in_operand_a),
    .in_operand_b      (in_operand_b),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result        (out_result),
    .out_a_greater     (out_a_greater),
    .out_a_less        (out_a_less),
    .out_a_equal       (out_a_equal),
    .out_overflow      (out_overflow),
    .out_divide_by_zero(out_divide_by_zero),
    .fail_count        (fail_count),
    .outstanding       (outstanding),
    .checked_count     (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("end of test: mismatches");
    $finish;
  end

  // Receiver: switch at random between stall styles, each held for a random span.
  initial begin
    stall_style_t style;
    int           span;
    int           phase;
    out_stall = 1'b0;
    phase     = 0;
    forever begin
      style = stall_style_t'($urandom_range(0, 3));
      span  = $urandom_range(32, 200);
      repeat (span) begin
        @(negedge clk);
        case (style)
          STALL_NONE:  out_stall = 1'b0;
          STALL_HALF:  out_stall = 1'($urandom_range(0, 1));
          STALL_HEAVY: out_stall = ($urandom_range(0, 3) != 0);
          default: begin
            out_stall = (phase % 9) < 6;
            phase++;
          end
        endcase
      end
    end
  end

  task automatic send_beat(logic [3:0] mode, logic [31:0] a, logic [31:0] b);
    @(negedge clk);
    in_valid     = 1'b1;
    in_mode      = mode;
    in_operand_a = a;
    in_operand_b = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
  endtask

  // Hold off the sender until every predicted beat has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_operand();
    logic [31:0] corners[8];
    corners = '{WORD_MAX, WORD_MIN, 32'h0, 32'h1, NEG_ONE, ONE_FIX, 32'hffff_ff00,
                32'h0000_0080};
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3, 4:    return 32'($urandom_range(0, 8191)) - 32'd4096;
      5:       return corners[$urandom_range(0, 7)];
      6:       return WORD_MAX - 32'($urandom_range(0, 255));
      7:       return WORD_MIN + 32'($urandom_range(0, 255));
      default: return 32'($urandom_range(0, 32'h1f_ffff)) - 32'h10_0000;
    endcase
  endfunction

  task automatic send_random_beat();
    logic [3:0]  mode;
    logic [31:0] a, b;
    mode = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI))
                                        : 4'($urandom_range(MODE_ADD, MODE_F2I));
    a = pick_operand();
    if ($urandom_range(0, 7) == 0)
      b = a;
    else if (mode == MODE_DIV && $urandom_range(0, 5) == 0)
      b = '0;
    else
      b = pick_operand();
    send_beat(mode, a, b);
  endtask

  initial begin
    int burst;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_mode      = MODE_ADD;
    in_operand_a = '0;
    in_operand_b = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // saturation on add and subtract
    send_beat(MODE_ADD, WORD_MAX, 32'h1);
    send_beat(MODE_ADD, WORD_MIN, WORD_MIN);
    send_beat(MODE_SUB, WORD_MIN, 32'h1);
    send_beat(MODE_SUB, 32'h0, WORD_MIN);
    send_beat(MODE_SUB, 32'h180, 32'hffff_ff80);
    // multiply: saturation both ways, rounding ties, exact most negative
    send_beat(MODE_MUL, WORD_MAX, WORD_MAX);
    send_beat(MODE_MUL, WORD_MIN, WORD_MAX);
    send_beat(MODE_MUL, 32'h80, 32'h1);
    send_beat(MODE_MUL, 32'hffff_ff80, 32'h1);
    send_beat(MODE_MUL, WORD_MIN, ONE_FIX);
    // divide: by zero, saturation, ties, a plain third
    send_beat(MODE_DIV, ONE_FIX, 32'h0);
    send_beat(MODE_DIV, WORD_MIN, 32'hffff_ff00);
    send_beat(MODE_DIV, 32'h1, 32'h200);
    send_beat(MODE_DIV, NEG_ONE, 32'h200);
    send_beat(MODE_DIV, ONE_FIX, 32'h300);
    // min and max, equal operands among them
    send_beat(MODE_MIN, 32'h1234, 32'h1234);
    send_beat(MODE_MAX, WORD_MIN, WORD_MAX);
    send_beat(MODE_MIN, WORD_MIN, WORD_MAX);
    // wrap on step, conversions
    send_beat(MODE_INC, WORD_MAX, 32'h0);
    send_beat(MODE_DEC, WORD_MIN, 32'h0);
    send_beat(MODE_I2F, 32'h1234_5678, NEG_ONE);
    send_beat(MODE_F2I, 32'hffff_ff01, 32'h0);
    send_beat(MODE_F2I, WORD_MAX, WORD_MAX);
    // unused codes still give compare flags
    send_beat(MODE_SPARE_LO, WORD_MAX, WORD_MIN);
    send_beat(MODE_SPARE_HI, WORD_MIN, WORD_MAX);
    directed_count = 25;
    wait_drained();

    random_count = 0;
    while (random_count < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        send_random_beat();
        random_count++;
        if (random_count % 250 == 0) wait_drained();
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 12));
    end

    wait_drained();
    idle_cycles(DRAIN_CYCLES);

    $display("covered %0d directed and %0d random operations, %0d result beats compared",
             directed_count, random_count, checked_count);
    $display("all ten operations, spare codes, saturation, ties and divide by zero");
    if (fail_count == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/fpa_pkg.sv
rtl/fpa_sat.sv
rtl/fpa_mul.sv
rtl/fpa_div.sv
rtl/fixed_point_q24_8_alu_top.sv
bench/fpa_result_checker.sv
bench/testbench.sv
